>>> hw/rtl/fuzzy_pd_inference_assert.svh
// Assertion macros shared by the fuzzy PD inference RTL.
`ifndef FUZZY_PD_INFERENCE_ASSERT_SVH
`define FUZZY_PD_INFERENCE_ASSERT_SVH
`ifndef SYNTH
`define FPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpd assertion failed");
`define FPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpd assertion failed");
`else
`define FPD_ASSERT(lbl, clk, rst_n, prop)
`define FPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/fpd_pkg.sv
// Types, constants and tables of the fuzzy PD inference block.
`default_nettype none
package fpd_pkg;
    localparam int ERR_W     = 10;
    localparam int CHG_W     = 13;
    localparam int LVL_W     = 13;
    localparam int MU_W      = 17;
    localparam int LAB_W     = 3;
    localparam int NUM_LVL   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int Q_CW      = 3;
    localparam int PROD_W    = 30;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 19;
    localparam int QUO_W     = 13;

    localparam logic [MU_W-1:0] MU_ONE = 17'd65536;

    // 65536/40 and 65536/20 split into integer part and remainder/5 correction
    localparam logic [16:0] E_K40 = 17'd1638;
    localparam logic [16:0] E_K20 = 17'd3276;
    localparam logic [15:0] RCP5  = 16'd205;      // ~2^10/5
    // 65536/1664 = 512/13, 65536/1536 = 128/3
    localparam logic [16:0] C_K13  = 17'd39;
    localparam logic [16:0] C_K3   = 17'd42;
    localparam logic [27:0] RCP13  = 28'd10083;   // ~2^17/13
    localparam logic [27:0] RCP3   = 28'd2731;    // ~2^13/3

    localparam logic signed [ERR_W-1:0] E_BP [0:6] =
        '{-10'sd100, -10'sd60, -10'sd40, 10'sd0, 10'sd40, 10'sd60, 10'sd100};
    // error change breakpoints in units of 1/1280
    localparam logic signed [15:0] C_BP [0:4] =
        '{-16'sd3200, -16'sd1536, 16'sd0, 16'sd1536, 16'sd3200};

    localparam logic [LAB_W-1:0] LAB_MAX = 3'd6;

    typedef logic [LAB_W-1:0] t_lab;
    typedef logic [MU_W-1:0]  t_mu;
    typedef logic [LVL_W-1:0] t_lvl;

    localparam t_lab RULE_TAB [0:6][0:4] = '{
        '{3'd4, 3'd3, 3'd1, 3'd0, 3'd0},
        '{3'd6, 3'd5, 3'd1, 3'd4, 3'd5},
        '{3'd7, 3'd6, 3'd1, 3'd5, 3'd6},
        '{3'd3, 3'd3, 3'd0, 3'd3, 3'd3},
        '{3'd6, 3'd5, 3'd1, 3'd3, 3'd4},
        '{3'd5, 3'd4, 3'd1, 3'd2, 3'd3},
        '{3'd1, 3'd1, 3'd1, 3'd0, 3'd0}
    };

    localparam t_lvl LVL_RESET [0:NUM_LVL-1] =
        '{13'd0, 13'd2880, 13'd3040, 13'd3520, 13'd4000, 13'd4480, 13'd4800};

    // one classified sample: left memberships and the four rule labels
    typedef struct packed {
        t_mu            p0;
        t_mu            d0;
        t_lab [3:0]     lab;
    } t_item;
endpackage
`default_nettype wire

>>> hw/rtl/fpd_ifs.sv
// Stream interfaces for samples in and drive values out.
`default_nettype none
interface fpd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [fpd_pkg::ERR_W-1:0]  error_value;
    logic signed [fpd_pkg::CHG_W-1:0]  error_change;
    modport source (output valid, error_value, error_change, input ready);
    modport sink   (input valid, error_value, error_change, output ready);
endinterface

interface fpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [fpd_pkg::LVL_W-1:0]  drive_value;
    modport source (output valid, drive_value, input ready);
    modport sink   (input valid, drive_value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fpd_front.sv
// Front end: segment search, memberships and rule label lookup.
`default_nettype none
module fpd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    fpd_in_if.sink             i_sample,
    output fpd_pkg::t_item     o_item,
    output logic               o_valid,
    input  wire logic          i_ready
);
    logic                              w_en;
    logic signed [fpd_pkg::ERR_W-1:0]  w_e;
    logic signed [fpd_pkg::ERR_W-1:0]  w_e_ref;
    logic signed [fpd_pkg::ERR_W-1:0]  w_e_dif;
    logic signed [15:0]                w_d;
    logic signed [15:0]                w_d_ref;
    logic signed [15:0]                w_d_dif;

    logic        r_a_vld, r_b_vld;
    logic        r_e_lo, r_e_hi, r_c_lo, r_c_hi;
    logic [2:0]  r_e_seg, n_e_seg;
    logic [1:0]  r_c_seg, n_c_seg;
    logic [5:0]  r_e_diff;
    logic [10:0] r_c_diff;
    fpd_pkg::t_item r_item, n_item;

    logic        w_e_nar, w_c_nar;
    logic [7:0]  w_e_t;
    logic [15:0] w_e_prod;
    logic [16:0] w_e_k;
    logic [13:0] w_c_t;
    logic [27:0] w_c_prod;
    logic [10:0] w_c_q;
    logic [16:0] w_c_k;
    logic [2:0]  w_pl1, w_dl, w_dl1;

    assign w_en           = !r_b_vld || i_ready;
    assign i_sample.ready = w_en;
    assign o_valid        = r_b_vld;
    assign o_item         = r_item;

    // stage A: find the segment and distance to its right breakpoint
    always_comb begin
        w_e = i_sample.error_value;
        w_d = $signed({{3{i_sample.error_change[12]}}, i_sample.error_change})
            + $signed({i_sample.error_change[12], i_sample.error_change, 2'b00});
        priority if (w_e <= fpd_pkg::E_BP[1]) begin
            n_e_seg = 3'd0; w_e_ref = fpd_pkg::E_BP[1];
        end else if (w_e <= fpd_pkg::E_BP[2]) begin
            n_e_seg = 3'd1; w_e_ref = fpd_pkg::E_BP[2];
        end else if (w_e <= fpd_pkg::E_BP[3]) begin
            n_e_seg = 3'd2; w_e_ref = fpd_pkg::E_BP[3];
        end else if (w_e <= fpd_pkg::E_BP[4]) begin
            n_e_seg = 3'd3; w_e_ref = fpd_pkg::E_BP[4];
        end else if (w_e <= fpd_pkg::E_BP[5]) begin
            n_e_seg = 3'd4; w_e_ref = fpd_pkg::E_BP[5];
        end else begin
            n_e_seg = 3'd5; w_e_ref = fpd_pkg::E_BP[6];
        end
        priority if (w_d <= fpd_pkg::C_BP[1]) begin
            n_c_seg = 2'd0; w_d_ref = fpd_pkg::C_BP[1];
        end else if (w_d <= fpd_pkg::C_BP[2]) begin
            n_c_seg = 2'd1; w_d_ref = fpd_pkg::C_BP[2];
        end else if (w_d <= fpd_pkg::C_BP[3]) begin
            n_c_seg = 2'd2; w_d_ref = fpd_pkg::C_BP[3];
        end else begin
            n_c_seg = 2'd3; w_d_ref = fpd_pkg::C_BP[4];
        end
        w_e_dif = w_e_ref - w_e;
        w_d_dif = w_d_ref - w_d;
    end

    // stage B: floor(diff * 65536 / width) as integer part plus a small
    // reciprocal correction; width 20 on error segments 1 and 4,
    // 1536 on change segments 1 and 2
    always_comb begin
        w_e_nar  = (r_e_seg == 3'd1) || (r_e_seg == 3'd4);
        w_e_t    = w_e_nar ? {r_e_diff, 2'b00} : {1'b0, r_e_diff, 1'b0};
        w_e_prod = 16'(w_e_t) * fpd_pkg::RCP5;
        w_e_k    = w_e_nar ? fpd_pkg::E_K20 : fpd_pkg::E_K40;

        w_c_nar  = (r_c_seg == 2'd1) || (r_c_seg == 2'd2);
        w_c_t    = w_c_nar ? {2'b00, r_c_diff, 1'b0}
                           : 14'({r_c_diff, 2'b00}) + 14'(r_c_diff);
        w_c_prod = 28'(w_c_t) * (w_c_nar ? fpd_pkg::RCP3 : fpd_pkg::RCP13);
        w_c_q    = w_c_nar ? w_c_prod[23:13] : w_c_prod[27:17];
        w_c_k    = w_c_nar ? fpd_pkg::C_K3 : fpd_pkg::C_K13;

        priority if (r_e_lo) begin
            n_item.p0 = fpd_pkg::MU_ONE;
        end else if (r_e_hi) begin
            n_item.p0 = '0;
        end else begin
            n_item.p0 = 17'(r_e_diff) * w_e_k + 17'(w_e_prod[15:10]);
        end
        priority if (r_c_lo) begin
            n_item.d0 = fpd_pkg::MU_ONE;
        end else if (r_c_hi) begin
            n_item.d0 = '0;
        end else begin
            n_item.d0 = 17'(r_c_diff) * w_c_k + 17'(w_c_q);
        end

        w_pl1 = r_e_seg + 3'd1;
        w_dl  = {1'b0, r_c_seg};
        w_dl1 = w_dl + 3'd1;
        n_item.lab[0] = fpd_pkg::RULE_TAB[r_e_seg][w_dl];
        n_item.lab[1] = fpd_pkg::RULE_TAB[w_pl1][w_dl];
        n_item.lab[2] = fpd_pkg::RULE_TAB[r_e_seg][w_dl1];
        n_item.lab[3] = fpd_pkg::RULE_TAB[w_pl1][w_dl1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_sample.valid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_lo   <= (w_e <= fpd_pkg::E_BP[0]);
            r_e_hi   <= (w_e >= fpd_pkg::E_BP[6]);
            r_c_lo   <= (w_d <= fpd_pkg::C_BP[0]);
            r_c_hi   <= (w_d >= fpd_pkg::C_BP[4]);
            r_e_seg  <= n_e_seg;
            r_c_seg  <= n_c_seg;
            r_e_diff <= w_e_dif[5:0];
            r_c_diff <= w_d_dif[10:0];
            r_item   <= n_item;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/fpd_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none
`include "fuzzy_pd_inference_assert.svh"
module fpd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fpd_pkg::t_item  i_item,
    input  wire logic            i_valid,
    output logic                 o_ready,
    output fpd_pkg::t_item       o_item,
    output logic                 o_valid,
    input  wire logic            i_ready
);
    fpd_pkg::t_item r_mem [0:fpd_pkg::Q_DEPTH-1];
    logic [fpd_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [fpd_pkg::Q_CW-1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != fpd_pkg::Q_CW'(fpd_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + fpd_pkg::Q_CW'(w_push) - fpd_pkg::Q_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

    `FPD_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= fpd_pkg::Q_CW'(fpd_pkg::Q_DEPTH))
endmodule
`default_nettype wire

>>> hw/rtl/fpd_back.sv
// Back end: rule weights, thinning, weighted sums and pipelined divide.
`default_nettype none
`include "fuzzy_pd_inference_assert.svh"
module fpd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fpd_pkg::t_item  i_item,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire fpd_pkg::t_lvl   i_lvl [0:fpd_pkg::NUM_LVL-1],
    fpd_out_if.source            o_result
);
    localparam int DIV_N = fpd_pkg::QUO_W;

    logic w_en;
    fpd_pkg::t_mu  w_p1, w_d1;
    fpd_pkg::t_mu  w_w [0:3];
    fpd_pkg::t_lab w_li;

    logic [2:0]  r_vs;
    fpd_pkg::t_mu  r1_w   [0:3];
    fpd_pkg::t_lvl r1_lvl [0:3], n1_lvl [0:3];
    logic [fpd_pkg::PROD_W-1:0] r2_prod [0:3];
    logic [fpd_pkg::DEN_W-1:0]  r2_den;
    logic [fpd_pkg::NUM_W-1:0]  r3_num;
    logic [fpd_pkg::DEN_W-1:0]  r3_den;

    logic [DIV_N-1:0]           r_vld;
    logic [fpd_pkg::NUM_W-1:0]  r_rem [0:DIV_N-1], s_rem [0:DIV_N-1], n_rem [0:DIV_N-1];
    logic [fpd_pkg::DEN_W-1:0]  r_den [0:DIV_N-1], s_den [0:DIV_N-1];
    logic [fpd_pkg::QUO_W-1:0]  r_q   [0:DIV_N-1], s_q   [0:DIV_N-1], n_q   [0:DIV_N-1];
    logic [DIV_N-1:0]           r_z, s_z;
    logic [fpd_pkg::NUM_W-1:0]  w_sh  [0:DIV_N-1];

    assign w_en              = !r_vld[DIV_N-1] || o_result.ready;
    assign o_ready           = w_en;
    assign o_result.valid    = r_vld[DIV_N-1];
    assign o_result.drive_value = r_q[DIV_N-1];

    // weights, then pairwise thinning of duplicate labels in fixed order
    always_comb begin
        w_p1   = fpd_pkg::MU_ONE - i_item.p0;
        w_d1   = fpd_pkg::MU_ONE - i_item.d0;
        w_w[0] = (i_item.p0 <= i_item.d0) ? i_item.p0 : i_item.d0;
        w_w[1] = (w_p1 <= i_item.d0) ? w_p1 : i_item.d0;
        w_w[2] = (i_item.p0 <= w_d1) ? i_item.p0 : w_d1;
        w_w[3] = (w_p1 <= w_d1) ? w_p1 : w_d1;
        for (int i = 0; i < 3; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if (i_item.lab[i] == i_item.lab[j]) begin
                    if (w_w[i] > w_w[j]) w_w[j] = '0;
                    else                 w_w[i] = '0;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            w_li      = (i_item.lab[i] > fpd_pkg::LAB_MAX) ? fpd_pkg::LAB_MAX
                                                           : i_item.lab[i];
            n1_lvl[i] = i_lvl[w_li];
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb begin
        s_rem[0] = r3_num;
        s_den[0] = r3_den;
        s_q[0]   = '0;
        s_z[0]   = (r3_den == '0);
        for (int k = 1; k < DIV_N; k++) begin
            s_rem[k] = r_rem[k-1];
            s_den[k] = r_den[k-1];
            s_q[k]   = r_q[k-1];
            s_z[k]   = r_z[k-1];
        end
        for (int k = 0; k < DIV_N; k++) begin
            w_sh[k] = fpd_pkg::NUM_W'(s_den[k]) << (DIV_N - 1 - k);
            if (s_rem[k] >= w_sh[k]) begin
                n_rem[k] = s_rem[k] - w_sh[k];
                n_q[k]   = s_q[k] | (fpd_pkg::QUO_W'(1) << (DIV_N - 1 - k));
            end else begin
                n_rem[k] = s_rem[k];
                n_q[k]   = s_q[k];
            end
        end
        // zero weight sum gives zero drive
        if (s_z[DIV_N-1]) n_q[DIV_N-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs  <= '0;
            r_vld <= '0;
        end else if (w_en) begin
            r_vs  <= {r_vs[1:0], i_valid};
            r_vld <= {r_vld[DIV_N-2:0], r_vs[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r1_w[i]    <= w_w[i];
                r1_lvl[i]  <= n1_lvl[i];
                r2_prod[i] <= fpd_pkg::PROD_W'(r1_w[i]) * fpd_pkg::PROD_W'(r1_lvl[i]);
            end
            r2_den <= fpd_pkg::DEN_W'(r1_w[0]) + fpd_pkg::DEN_W'(r1_w[1])
                    + fpd_pkg::DEN_W'(r1_w[2]) + fpd_pkg::DEN_W'(r1_w[3]);
            r3_num <= fpd_pkg::NUM_W'(r2_prod[0]) + fpd_pkg::NUM_W'(r2_prod[1])
                    + fpd_pkg::NUM_W'(r2_prod[2]) + fpd_pkg::NUM_W'(r2_prod[3]);
            r3_den <= r2_den;
            for (int k = 0; k < DIV_N; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= s_den[k];
                r_q[k]   <= n_q[k];
                r_z[k]   <= s_z[k];
            end
        end
    end

    `FPD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_vld))
    `FPD_ASSERT(a_zero_drive, i_clk, i_rst_n, (r_vld[DIV_N-1] && r_z[DIV_N-1]) |-> (r_q[DIV_N-1] == '0))
    `FPD_ASSERT(a_quo_fits, i_clk, i_rst_n, (r_vs[2] && r3_den != '0) |-> (r3_num < {r3_den, 13'b0}))
endmodule
`default_nettype wire

>>> hw/rtl/fuzzy_pd_inference.sv
// Throughput: one transaction per cycle while o_result.ready stays high; the front
// end (2 stages) and back end (3 weight/sum stages, 13-stage one-bit-per-stage
// divider) run decoupled through a 4-entry FIFO. Synchronous active-low reset
// clears all valid state and loads the output levels with their defaults.
`default_nettype none
module fuzzy_pd_inference (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    fpd_in_if.sink                                 i_sample,
    fpd_out_if.source                              o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [fpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fpd_pkg::LVL_W-1:0]         i_cfg_data
);
    // output level registers; label seven maps onto the last one in the back end
    fpd_pkg::t_lvl r_lvl [0:fpd_pkg::NUM_LVL-1];

    fpd_pkg::t_item w_f_item, w_q_item;
    logic           w_f_vld, w_f_rdy, w_q_vld, w_q_rdy;

    // config writes to an index past the last level are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= fpd_pkg::LVL_RESET;
        end else if (i_cfg_we && (i_cfg_idx < fpd_pkg::CFG_IDX_W'(fpd_pkg::NUM_LVL))) begin
            r_lvl[i_cfg_idx] <= i_cfg_data;
        end
    end

    // front end: classify each sample into memberships and rule labels
    fpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .o_item   (w_f_item),
        .o_valid  (w_f_vld),
        .i_ready  (w_f_rdy)
    );

    // decoupling FIFO so either side can stall alone
    fpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_f_item),
        .i_valid  (w_f_vld),
        .o_ready  (w_f_rdy),
        .o_item   (w_q_item),
        .o_valid  (w_q_vld),
        .i_ready  (w_q_rdy)
    );

    // back end: inference, weighted average and output register
    fpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_q_item),
        .i_valid  (w_q_vld),
        .o_ready  (w_q_rdy),
        .i_lvl    (r_lvl),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the fuzzy PD inference block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    // configuration register indexes; index 7 has no register behind it
    localparam int REG_LEVEL_BASE = 0;
    localparam int REG_UNUSED     = 7;
    localparam int RESULT_LATENCY = 18;
    localparam int DRAIN_CYCLES   = RESULT_LATENCY + fpd_pkg::Q_DEPTH + 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_SET  = 270;
    localparam int Q16_ONE        = 65536;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [fpd_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [fpd_pkg::LVL_W-1:0] i_cfg_data = '0;

    fpd_in_if  sample_if ();
    fpd_out_if result_if ();

    fuzzy_pd_inference dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Testbench copy of the output levels and the queue of pending drive values.
    fpd_pkg::t_lvl level_copy [0:fpd_pkg::NUM_LVL-1];
    fpd_pkg::t_lvl drive_q [$];
    int   fail_count = 0;
    int   cycle_count = 0;
    bit   no_gaps = 1'b0;    // stretch with back-to-back transactions on both sides

    // Breakpoints widened to seven entries so one routine serves both inputs.
    int err_pts [0:6] = '{-100, -60, -40, 0, 40, 60, 100};
    int chg_pts [0:6] = '{-3200, -1536, 0, 1536, 3200, 0, 0};

    // Triangular membership: left segment and Q1.16 membership of its left label.
    function automatic void membership(input int x, input int pts [0:6], input int n,
                                       output int seg, output int mu_left);
        int k;
        if (x <= pts[0]) begin
            seg = 0;
            mu_left = Q16_ONE;
        end else if (x >= pts[n-1]) begin
            seg = n - 2;
            mu_left = 0;
        end else begin
            k = 1;
            while (k < n - 1 && x > pts[k]) k++;
            seg = k - 1;
            mu_left = int'((longint'(pts[k] - x) * Q16_ONE) / (pts[k] - pts[k-1]));
        end
    endfunction

    // Expected drive value for one sample under the current output levels.
    function automatic fpd_pkg::t_lvl drive_for(
            input logic signed [fpd_pkg::ERR_W-1:0] err,
            input logic signed [fpd_pkg::CHG_W-1:0] chg);
        int pl, dl, p0, d0, p1, d1, lv;
        int w [0:3];
        fpd_pkg::t_lab lab [0:3];
        longint num, den;
        membership(int'(err), err_pts, 7, pl, p0);
        membership(int'(chg) * 5, chg_pts, 5, dl, d0);
        p1 = Q16_ONE - p0;
        d1 = Q16_ONE - d0;
        lab[0] = fpd_pkg::RULE_TAB[pl][dl];
        lab[1] = fpd_pkg::RULE_TAB[pl+1][dl];
        lab[2] = fpd_pkg::RULE_TAB[pl][dl+1];
        lab[3] = fpd_pkg::RULE_TAB[pl+1][dl+1];
        w[0] = (p0 <= d0) ? p0 : d0;
        w[1] = (p1 <= d0) ? p1 : d0;
        w[2] = (p0 <= d1) ? p0 : d1;
        w[3] = (p1 <= d1) ? p1 : d1;
        // duplicate labels: keep the strictly larger weight, the later one on a tie
        for (int i = 0; i < 3; i++)
            for (int j = i + 1; j < 4; j++)
                if (lab[i] == lab[j]) begin
                    if (w[i] > w[j]) w[j] = 0;
                    else w[i] = 0;
                end
        num = 0;
        den = 0;
        for (int i = 0; i < 4; i++) begin
            lv = (lab[i] > fpd_pkg::LAB_MAX) ? int'(fpd_pkg::LAB_MAX) : int'(lab[i]);
            num += longint'(w[i]) * level_copy[lv];
            den += w[i];
        end
        return (den == 0) ? fpd_pkg::t_lvl'(0) : fpd_pkg::t_lvl'(num / den);
    endfunction

    // Send one sample transaction; returns at the edge where it was accepted.
    task automatic send_sample(input logic signed [fpd_pkg::ERR_W-1:0] err,
                               input logic signed [fpd_pkg::CHG_W-1:0] chg,
                               input bit fixed, input fpd_pkg::t_lvl fixed_val);
        int gap;
        fpd_pkg::t_lvl exp_val;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.error_value  <= err;
        sample_if.error_change <= chg;
        do @(posedge i_clk); while (!sample_if.ready);
        exp_val = drive_for(err, chg);
        if (fixed && exp_val != fixed_val) begin
            $display("%0t: drive_value table/predictor disagree: expected %0d, actual %0d",
                     $time, fixed_val, exp_val);
            fail_count++;
        end
        drive_q.push_back(fixed ? fixed_val : exp_val);
        if ($urandom_range(0, 40) == 0) no_gaps = !no_gaps;
    endtask

    // Wait until every drive value has come back and the pipeline is empty.
    task automatic drain;
        if (sample_if.valid) sample_if.valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write strobe stays up across back-to-back writes; the caller drops it.
    task automatic write_reg(input int idx, input fpd_pkg::t_lvl val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= fpd_pkg::CFG_IDX_W'(idx);
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx < fpd_pkg::NUM_LVL) level_copy[idx] = val;
    endtask

    // Random sample: half full-range, half concentrated around the breakpoints.
    task automatic random_sample;
        logic signed [fpd_pkg::ERR_W-1:0] err;
        logic signed [fpd_pkg::CHG_W-1:0] chg;
        err = ($urandom_range(0, 1) == 0) ? fpd_pkg::ERR_W'($urandom)
              : fpd_pkg::ERR_W'(int'($urandom_range(0, 220)) - 110);
        chg = ($urandom_range(0, 1) == 0) ? fpd_pkg::CHG_W'($urandom)
              : fpd_pkg::CHG_W'(int'($urandom_range(0, 1400)) - 700);
        send_sample(err, chg, 1'b0, '0);
    endtask

    // Directed rows: extremes, breakpoints, rule label seven, equal-weight ties.
    typedef struct {
        logic signed [fpd_pkg::ERR_W-1:0] err;
        logic signed [fpd_pkg::CHG_W-1:0] chg;
        bit   fixed;
        fpd_pkg::t_lvl drive;
    } t_row;

    t_row rows [] = '{
        '{-10'sd512, -13'sd4096, 1'b1, 13'd4000},  // both inputs below range
        '{ 10'sd511,  13'sd4095, 1'b1, 13'd0},     // both inputs above range
        '{-10'sd40,  -13'sd4096, 1'b1, 13'd4800},  // rule label seven, clamped
        '{ 10'sd0,    13'sd0,    1'b1, 13'd0},     // center point
        '{-10'sd512,  13'sd4095, 1'b0, 13'd0},
        '{ 10'sd511, -13'sd4096, 1'b0, 13'd0},
        '{-10'sd100, -13'sd640,  1'b0, 13'd0},     // exactly on the outer breakpoints
        '{ 10'sd100,  13'sd640,  1'b0, 13'd0},
        '{-10'sd80,  -13'sd307,  1'b0, 13'd0},     // half memberships, tied weights
        '{ 10'sd20,   13'sd154,  1'b0, 13'd0},
        '{-10'sd50,   13'sd0,    1'b0, 13'd0},
        '{ 10'sd50,  -13'sd154,  1'b0, 13'd0},
        '{-10'sd1,    13'sd1,    1'b0, 13'd0},
        '{-10'sd61,  -13'sd500,  1'b0, 13'd0},
        '{ 10'sd255,  -13'sd1,   1'b0, 13'd0},
        '{-10'sd256,  13'sd2047, 1'b0, 13'd0}
    };

    // Result side: random stall before each transaction, then hold ready.
    initial begin
        int stall;
        result_if.ready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_if.valid && i_rst_n));
        end
    end

    // Compare each drive value transaction with the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected drive_value transaction, actual %0d",
                         $time, result_if.drive_value);
                fail_count++;
            end else if (result_if.drive_value !== drive_q[0]) begin
                $display("%0t: drive_value mismatch: expected %0d, actual %0d",
                         $time, drive_q[0], result_if.drive_value);
                fail_count++;
                void'(drive_q.pop_front());
            end else begin
                void'(drive_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        sample_if.valid        = 1'b0;
        sample_if.error_value  = '0;
        sample_if.error_change = '0;
        for (int i = 0; i < fpd_pkg::NUM_LVL; i++) level_copy[i] = fpd_pkg::LVL_RESET[i];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_sample(rows[r].err, rows[r].chg, rows[r].fixed, rows[r].drive);
        repeat (ITEMS_PER_SET) random_sample();

        // level sets: all at max, all zero, alternating extremes, random
        for (int s = 0; s < 4; s++) begin
            drain();
            for (int i = 0; i < fpd_pkg::NUM_LVL; i++) begin
                case (s)
                    0: write_reg(REG_LEVEL_BASE + i, fpd_pkg::t_lvl'(8191));
                    1: write_reg(REG_LEVEL_BASE + i, fpd_pkg::t_lvl'(0));
                    2: write_reg(REG_LEVEL_BASE + i,
                                 (i % 2 == 0) ? fpd_pkg::t_lvl'(8191) : fpd_pkg::t_lvl'(0));
                    default: write_reg(REG_LEVEL_BASE + i, fpd_pkg::t_lvl'($urandom));
                endcase
            end
            // a write to the unused index must leave every level alone
            write_reg(REG_UNUSED, fpd_pkg::t_lvl'($urandom));
            i_cfg_we <= 1'b0;
            if (s == 0) begin
                send_sample(-10'sd512, -13'sd4096, 1'b1, 13'd8191);
                send_sample(10'sd511, 13'sd4095, 1'b1, 13'd8191);
            end
            repeat (ITEMS_PER_SET) random_sample();
        end

        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
